// ----- rtl/aging_reference_count_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the aging reference count table
// Shared property wrappers. Each one is clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef AGING_REFERENCE_COUNT_TABLE_ASSERT_SVH
`define AGING_REFERENCE_COUNT_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARCT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/arct_pkg.sv -----
// ----------------------------------------------------------------------------
// arct_pkg
// Types, codes and default sizes for the aging reference count table.
// ----------------------------------------------------------------------------
package arct_pkg;

   localparam int ARCT_ENTRIES  = 64;
   localparam int ARCT_KEY_BITS = 32;
   localparam int ARCT_REF_BITS = 16;

   localparam int CSR_DATA_BITS = 7;

   // Configuration register indexes.
   localparam logic CSR_HIGH_WATER = 1'b0;
   localparam logic CSR_LOW_WATER  = 1'b1;

   // Request kinds.
   localparam logic KIND_REFERENCE = 1'b0;
   localparam logic KIND_CLEAN     = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_HIT      = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;
   localparam logic [1:0] ST_CLEANED  = 2'd3;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] occupancy;
      logic [6:0] removed;
      logic       below_low_water;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] full_level;
      logic [CSR_DATA_BITS-1:0] low_level;
   } cfg_type;

endpackage

// ----- rtl/arct_ram.sv -----
// ----------------------------------------------------------------------------
// arct_ram
// Generic simple dual port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module arct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/arct_csr.sv -----
// ----------------------------------------------------------------------------
// arct_csr
// Configuration registers: high and low water marks.
// ----------------------------------------------------------------------------
module arct_csr
   import arct_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HIGH_WATER: cfg_in.full_level = csr_wdata;
            CSR_LOW_WATER:  cfg_in.low_level  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_level <= CSR_DATA_BITS'(64);
         cfg_ff.low_level  <= CSR_DATA_BITS'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/aging_reference_count_table.sv -----
// ----------------------------------------------------------------------------
// aging_reference_count_table
// Key table with saturating reference counts, aging clean pass and occupancy.
// ----------------------------------------------------------------------------
// Sequence: an accepted request starts a scan that reads the entry memory one entry
//    a cycle; a hit ends the scan early, while a miss or a clean reads every entry.
// Flow: one request at a time; a stalled response keeps the block in its finish state,
//    holding off the next request, until the output frees up.
// Reset: synchronous. After reset a clearing pass writes every entry invalid, during
//    which requests are stalled; configuration writes are taken.
module aging_reference_count_table
   import arct_pkg::*;
#(
   parameter int ENTRIES  = ARCT_ENTRIES,
   parameter int KEY_BITS = ARCT_KEY_BITS,
   parameter int REF_BITS = ARCT_REF_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   `include "aging_reference_count_table_assert.svh"

   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = IDX_BITS + 1;
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (OCC_BITS > CSR_DATA_BITS) ? OCC_BITS : CSR_DATA_BITS;
   localparam int WORD_BITS = 1 + KEY_BITS + REF_BITS;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;

   cfg_type cfg;

   arct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Each memory word holds {valid, key, refs}.
   logic                 ram_wr_en;
   logic [IDX_BITS-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_BITS-1:0]  ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   arct_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic [2:0]          state_ff,       state_in;
   logic [CNT_BITS-1:0] rd_cnt_ff,      rd_cnt_in;
   logic [IDX_BITS-1:0] pidx_ff,        pidx_in;
   logic                dval_ff,        dval_in;
   logic                kind_ff,        kind_in;
   logic [KEY_BITS-1:0] key_ff,         key_in;
   logic [IDX_BITS-1:0] free_ff,        free_in;
   logic                free_found_ff,  free_found_in;
   logic [OCC_BITS-1:0] occ_ff,         occ_in;
   logic [OCC_BITS-1:0] freed_ff,       freed_in;
   logic [1:0]          status_ff,      status_in;
   logic                rsp_valid_ff,   rsp_valid_in;
   rsp_type             rsp_data_ff,    rsp_data_in;

   logic                req_accept;
   logic signed [63:0]  key_wide;
   logic                ent_valid;
   logic [KEY_BITS-1:0] ent_key;
   logic [REF_BITS-1:0] ent_refs;
   logic [REF_BITS-1:0] refs_inc;
   logic [REF_BITS-1:0] refs_dec;
   logic                last_entry;
   logic                free_now;
   logic [IDX_BITS-1:0] free_slot;
   logic                at_high_water;

   // Requests are only taken between scans; a finished response waiting in the
   // output register does not hold off the next request.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The key is sign extended and then cut to the stored key width.
   assign key_wide = 64'(req_data.key);

   assign ent_valid = ram_rd_data[WORD_BITS-1];
   assign ent_key   = ram_rd_data[KEY_BITS+REF_BITS-1:REF_BITS];
   assign ent_refs  = ram_rd_data[REF_BITS-1:0];

   assign refs_inc = (ent_refs == '1) ? ent_refs : ent_refs + REF_BITS'(1);
   assign refs_dec = (ent_refs != '0) ? ent_refs - REF_BITS'(1) : '0;

   assign last_entry    = (pidx_ff == IDX_BITS'(ENTRIES - 1));
   assign free_now      = free_found_ff || !ent_valid;
   assign free_slot     = free_found_ff ? free_ff : pidx_ff;
   assign at_high_water = (CMP_BITS'(occ_ff) >= CMP_BITS'(cfg.full_level));

   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      pidx_in       = pidx_ff;
      dval_in       = 1'b0;
      kind_in       = kind_ff;
      key_in        = key_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      occ_in        = occ_ff;
      freed_in      = freed_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = pidx_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_cnt_ff[IDX_BITS-1:0];

      case (state_ff)
         S_CLEAR: begin
            // Sweep the memory once, marking every entry invalid.
            ram_wr_en   = 1'b1;
            ram_wr_addr = rd_cnt_ff[IDX_BITS-1:0];
            ram_wr_data = '0;
            rd_cnt_in   = rd_cnt_ff + CNT_BITS'(1);
            if (rd_cnt_ff[IDX_BITS-1:0] == IDX_BITS'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               kind_in       = req_data.kind;
               key_in        = key_wide[KEY_BITS-1:0];
               rd_cnt_in     = '0;
               free_found_in = 1'b0;
               freed_in      = '0;
               state_in      = S_SCAN;
            end
         end

         S_SCAN: begin
            // Issue stage: one read a cycle until every entry has been read or a hit ends the scan.
            if (rd_cnt_ff < CNT_BITS'(ENTRIES)) begin
               ram_rd_en = 1'b1;
               rd_cnt_in = rd_cnt_ff + CNT_BITS'(1);
               pidx_in   = rd_cnt_ff[IDX_BITS-1:0];
               dval_in   = 1'b1;
            end

            // Data stage: the entry read in the previous cycle is here. Each
            // entry is read and written back at most once per pass, so the
            // write never races a read of the same entry.
            if (dval_ff) begin
               if (kind_ff == KIND_CLEAN) begin
                  if (ent_valid) begin
                     ram_wr_en = 1'b1;
                     if (refs_dec == '0) begin
                        ram_wr_data = '0;
                        freed_in    = freed_ff + OCC_BITS'(1);
                        if (occ_ff != '0) begin
                           occ_in = occ_ff - OCC_BITS'(1);
                        end
                     end else begin
                        ram_wr_data = {1'b1, ent_key, refs_dec};
                     end
                  end
                  if (last_entry) begin
                     status_in = ST_CLEANED;
                     state_in  = S_FINISH;
                     dval_in   = 1'b0;
                  end
               end else if (ent_valid && (ent_key == key_ff)) begin
                  // Hit: bump the count and stop the scan early.
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, ent_key, refs_inc};
                  status_in   = ST_HIT;
                  state_in    = S_FINISH;
                  dval_in     = 1'b0;
               end else begin
                  if (!ent_valid && !free_found_ff) begin
                     free_in       = pidx_ff;
                     free_found_in = 1'b1;
                  end
                  if (last_entry) begin
                     if (at_high_water || !free_now) begin
                        status_in = ST_REJECTED;
                     end else begin
                        // Miss with room left: insert at the lowest free entry.
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = free_slot;
                        ram_wr_data = {1'b1, key_ff, REF_BITS'(1)};
                        occ_in      = occ_ff + OCC_BITS'(1);
                        status_in   = ST_INSERTED;
                     end
                     state_in = S_FINISH;
                     dval_in  = 1'b0;
                  end
               end
            end
         end

         S_FINISH: begin
            // Hand the response to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.occupancy       = 7'(occ_ff);
               rsp_data_in.removed         = 7'(freed_ff);
               rsp_data_in.below_low_water =
                  (CMP_BITS'(occ_ff) < CMP_BITS'(cfg.low_level));
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rd_cnt_ff     <= '0;
         dval_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         occ_ff        <= '0;
         freed_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         dval_ff       <= dval_in;
         free_found_ff <= free_found_in;
         occ_ff        <= occ_in;
         freed_ff      <= freed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      free_ff     <= free_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Occupancy can never count more entries than the table has.
   `ARCT_ASSERT_SAME(a_occ_bound, 1'b1, occ_ff <= OCC_BITS'(ENTRIES),
      "occupancy exceeds table size")
   // The entry memory is only written by the clearing sweep or a scan.
   `ARCT_ASSERT_SAME(a_wr_state, ram_wr_en, state_ff == S_CLEAR || state_ff == S_SCAN,
      "entry memory written outside clear or scan")
   // A clean pass never raises occupancy.
   `ARCT_ASSERT_NEXT(a_clean_occ, state_ff == S_SCAN && kind_ff == KIND_CLEAN,
      occ_ff <= $past(occ_ff), "clean pass raised occupancy")
   // Removed is only nonzero in responses to a clean pass.
   `ARCT_ASSERT_SAME(a_removed_clean,
      rsp_valid_ff && rsp_data_ff.status != ST_CLEANED, rsp_data_ff.removed == 7'd0,
      "removed count on a reference response")

endmodule

// ----- tb/sv/aging_reference_count_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aging_reference_count_table_tb
// Self-checking bench for the aging reference count table. A scoreboard keeps
// its own copy of the key table, predicts the response of every accepted
// request, and compares each response field by field. Stimulus is a short
// directed sequence followed by random phases under several water marks.
// ----------------------------------------------------------------------------
module aging_reference_count_table_tb;
   import arct_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 8;
   // One full scan of the entry memory plus the pipeline around it.
   localparam int SCAN_CYCLES     = ARCT_ENTRIES + 3;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 8;
   localparam int REQS_PER_PHASE  = 92;
   localparam int HOLD_OFF_PHASE  = 2;

   // Scoreboard: a private copy of the key table that is aged and looked up
   // in the same order as the block sees accepted requests. Each request
   // leaves one predicted response in a queue, oldest first.
   class refcount_scoreboard;
      logic                     slot_used [ARCT_ENTRIES];
      logic [ARCT_KEY_BITS-1:0] slot_key  [ARCT_ENTRIES];
      logic [ARCT_REF_BITS-1:0] slot_refs [ARCT_ENTRIES];
      int unsigned              occupancy;
      int unsigned              high_water;
      int unsigned              low_water;
      rsp_type                  predicted_rsp [$];
      int unsigned              mismatches;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_refs[i] = '0;
         end
         occupancy  = 0;
         high_water = 64;
         low_water  = 16;
         mismatches = 0;
      endfunction

      function void set_register(logic index, logic [CSR_DATA_BITS-1:0] value);
         if (index == CSR_HIGH_WATER) begin
            high_water = value;
         end else begin
            low_water = value;
         end
      endfunction

      function void predict_request(req_type req);
         rsp_type                  want;
         logic signed [63:0]       wide_key;
         logic [ARCT_KEY_BITS-1:0] lookup_key;
         int                       free_slot;
         int unsigned              freed;
         bit                       found;
         want = '0;
         if (req.kind == KIND_CLEAN) begin
            // Aging pass: every live count drops by one, and a slot whose
            // count reaches zero is released.
            freed = 0;
            for (int i = 0; i < ARCT_ENTRIES; i++) begin
               if (slot_used[i]) begin
                  if (slot_refs[i] != '0) slot_refs[i]--;
                  if (slot_refs[i] == '0) begin
                     slot_used[i] = 1'b0;
                     freed++;
                     if (occupancy > 0) occupancy--;
                  end
               end
            end
            want.status  = ST_CLEANED;
            want.removed = 7'(freed);
         end else begin
            // The key is sign-extended and then cut to the stored key width.
            wide_key   = req.key;
            lookup_key = wide_key[ARCT_KEY_BITS-1:0];
            free_slot  = -1;
            found      = 1'b0;
            for (int i = 0; i < ARCT_ENTRIES; i++) begin
               if (!found) begin
                  if (slot_used[i]) begin
                     if (slot_key[i] == lookup_key) begin
                        found = 1'b1;
                        if (slot_refs[i] != '1) slot_refs[i]++;
                     end
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
            end
            if (found) begin
               want.status = ST_HIT;
            end else if (occupancy >= high_water || free_slot < 0) begin
               want.status = ST_REJECTED;
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_key[free_slot]  = lookup_key;
               slot_refs[free_slot] = 1;
               occupancy++;
               want.status = ST_INSERTED;
            end
         end
         want.occupancy       = 7'(occupancy);
         want.below_low_water = (occupancy < low_water);
         predicted_rsp.push_back(want);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (predicted_rsp.size() == 0) begin
            report($sformatf("response %h with no request outstanding", got));
            return;
         end
         want = predicted_rsp.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.occupancy !== want.occupancy)
            report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
         if (got.removed !== want.removed)
            report($sformatf("removed %0d, expected %0d", got.removed, want.removed));
         if (got.below_low_water !== want.below_low_water)
            report($sformatf("below_low_water %0b, expected %0b",
                             got.below_low_water, want.below_low_water));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_wr_en;
   logic                     csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   refcount_scoreboard scoreboard;
   int unsigned        cycle_count = 0;
   // Raised by the stimulus to make the response side hold off for a long
   // stretch; the response process clears it when it takes the request.
   bit                 hold_off_pending = 1'b0;

   // Water marks, clean percentage and key pool size for each random phase.
   // The last phase draws its water marks at random.
   int unsigned phase_high_water [RANDOM_PHASES] = '{64, 127, 1, 0, 32, 64, 127, 0};
   int unsigned phase_low_water  [RANDOM_PHASES] = '{16, 64, 0, 127, 127, 0, 127, 0};
   int unsigned phase_clean_pct  [RANDOM_PHASES] = '{15, 2, 20, 10, 10, 30, 1, 15};
   int unsigned phase_pool_size  [RANDOM_PHASES] = '{24, 90, 8, 16, 40, 12, 100, 30};

   aging_reference_count_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Idle lengths: half of them zero, most of the rest short, a few long.
   function automatic int next_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Offers one request from a falling edge and holds it until the block
   // takes it. The scoreboard sees the request at the accepting edge, and
   // the task returns at the following falling edge with valid still high.
   task automatic offer_request(input logic kind, input logic [31:0] key);
      req_type req;
      req.kind = kind;
      req.key  = key;
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall);
      scoreboard.predict_request(req);
      @(negedge clock);
   endtask

   // Drops valid for the given number of cycles. Valid is only lowered when
   // there really is a gap, so a back-to-back request never sees valid
   // lowered and raised at the same edge.
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic offer_then_idle(input logic kind, input logic [31:0] key);
      offer_request(kind, key);
      idle_sender(next_gap());
   endtask

   // Stops offering requests until every predicted response has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (scoreboard.predicted_rsp.size() != 0) @(negedge clock);
   endtask

   // Register writes are only issued while no request is in flight, so the
   // scoreboard takes the new value at once.
   task automatic write_register(input logic index, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      scoreboard.set_register(index, CSR_DATA_BITS'(value));
   endtask

   // Response side. Each falling edge drives the stall exactly once: a long
   // requested hold-off first, then random stall bursts separated by runs
   // of free flow, some of them long enough to cover many requests.
   initial begin : response_sink
      int hold_left;
      int stall_left;
      int run_left;
      hold_left  = 0;
      stall_left = 0;
      run_left   = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
            rsp_stall <= 1'b0;
         end else begin
            run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 8);
            stall_left = next_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every response taken by the bench is checked against the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_response(rsp_data);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("aging_reference_count_table test failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned key_pool [$];
      int unsigned high_water;
      int unsigned low_water;
      scoreboard = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_HIGH_WATER;
      csr_wdata  = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A tiny high water mark lets the directed part reach rejection with
      // only a few keys. These writes land during the clearing pass, which
      // the block accepts; requests simply stall until the pass is over.
      write_register(CSR_HIGH_WATER, 3);
      write_register(CSR_LOW_WATER, 2);

      // Clean on an empty table, then inserts of the key extremes until the
      // high water mark is reached and the next new key is turned away.
      offer_then_idle(KIND_CLEAN, 32'h0000_0000);
      offer_then_idle(KIND_REFERENCE, 32'h0000_0000);
      offer_then_idle(KIND_REFERENCE, 32'h7FFF_FFFF);
      offer_then_idle(KIND_REFERENCE, 32'h8000_0000);
      offer_then_idle(KIND_REFERENCE, 32'hFFFF_FFFF);
      // A hit raises the count, so the next clean frees only the other two.
      offer_then_idle(KIND_REFERENCE, 32'h0000_0000);
      offer_then_idle(KIND_CLEAN, 32'hFFFF_FFFF);
      offer_then_idle(KIND_REFERENCE, 32'hAAAA_AAAA);
      offer_then_idle(KIND_REFERENCE, 32'h5555_5555);

      // With a high water mark of zero every new key is refused while hits
      // on keys already present still count.
      wait_for_drain();
      repeat (SCAN_CYCLES) @(negedge clock);
      write_register(CSR_HIGH_WATER, 0);
      write_register(CSR_LOW_WATER, 0);
      offer_then_idle(KIND_REFERENCE, 32'h5555_5555);
      offer_then_idle(KIND_REFERENCE, 32'h1234_5678);
      offer_then_idle(KIND_CLEAN, 32'h0000_0000);
      offer_then_idle(KIND_CLEAN, 32'h0000_0000);
      offer_then_idle(KIND_REFERENCE, 32'h0000_0000);

      // Random phases. Most references come from a small pool of keys so
      // that hits, saturation of occupancy and aging interact; the rest are
      // fresh random keys. Phases with a high mark above the table size and
      // few cleans fill all slots and then reject for lack of a free slot.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_drain();
         repeat (SCAN_CYCLES) @(negedge clock);
         high_water = phase_high_water[p];
         low_water  = phase_low_water[p];
         if (p == RANDOM_PHASES - 1) begin
            high_water = $urandom_range(0, 127);
            low_water  = $urandom_range(0, 127);
         end
         write_register(CSR_HIGH_WATER, high_water);
         write_register(CSR_LOW_WATER, low_water);

         key_pool.delete();
         for (int k = 0; k < phase_pool_size[p]; k++) key_pool.push_back($urandom());

         // In the pressure phase the response side stalls for a long time
         // while requests keep coming back to back, so the block fills up
         // and stalls its request input.
         if (p == HOLD_OFF_PHASE) hold_off_pending = 1'b1;

         for (int n = 0; n < REQS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < phase_clean_pct[p]) begin
               offer_request(KIND_CLEAN, $urandom());
            end else if ($urandom_range(0, 15) == 0) begin
               offer_request(KIND_REFERENCE, $urandom());
            end else begin
               offer_request(KIND_REFERENCE,
                             key_pool[$urandom_range(0, key_pool.size() - 1)]);
            end
            if (p == HOLD_OFF_PHASE && n < 10) begin
               // Keep offering without a break during the hold-off.
            end else if ($urandom_range(0, 49) == 0) begin
               wait_for_drain();
            end else begin
               idle_sender(next_gap());
            end
         end
      end

      // Let every outstanding response come back, then wait to see whether the block
      // shows any response nobody asked for.
      wait_for_drain();
      repeat (2 * SCAN_CYCLES) @(posedge clock);
      if (scoreboard.predicted_rsp.size() != 0) begin
         scoreboard.report($sformatf("%0d responses never arrived",
                                     scoreboard.predicted_rsp.size()));
      end
      if (scoreboard.mismatches == 0) begin
         $display("aging_reference_count_table test passed");
      end else begin
         $display("aging_reference_count_table test failed");
      end
      $finish;
   end

endmodule
